// ===== rtl/isort_pkg.sv =====
`timescale 1ns / 1ps

package isort_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int IDX_W   = 8;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_SWAP = 2'd2;

    localparam logic EV_COMPARE = 1'b0;
    localparam logic EV_SWAP    = 1'b1;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] hi_idx;
        logic [IDX_W-1:0] lo_idx;
    } cell_ctrl_t;

endpackage

// ===== rtl/isort_cell.sv =====
`timescale 1ns / 1ps

module isort_cell #(
    parameter int IDX = 0
) (
    input  logic                                 aclk,
    input  isort_pkg::cell_ctrl_t                ctrl,
    input  logic signed [isort_pkg::DATA_W-1:0]  ins_value,
    input  logic signed [isort_pkg::DATA_W-1:0]  prev_data,
    output logic signed [isort_pkg::DATA_W-1:0]  data,
    output logic                                 hit
);

    logic signed [isort_pkg::DATA_W-1:0] data_reg;
    logic                                is_hi;
    logic                                is_lo;

    assign is_hi = (ctrl.hi_idx == isort_pkg::IDX_W'(IDX));
    assign is_lo = (ctrl.lo_idx == isort_pkg::IDX_W'(IDX));

    // this cell sits just below the cursor and holds a larger value
    assign hit  = is_lo && (data_reg > ins_value);
    assign data = data_reg;

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            isort_pkg::OP_LOAD: begin
                if (is_hi) begin
                    data_reg <= ins_value;
                end
            end
            isort_pkg::OP_SWAP: begin
                if (is_hi) begin
                    data_reg <= prev_data;
                end else if (is_lo) begin
                    data_reg <= ins_value;
                end
            end
            default: begin
                data_reg <= data_reg;
            end
        endcase
    end

endmodule

// ===== rtl/insertion_sort_event_trace_unit.sv =====
`timescale 1ns / 1ps

// Online insertion sort with a compare/swap event trace.
// Input channel (s_*): one signed value per request; s_start_new empties the
// stored array first. Output channel (m_*): one request per event, with the
// positions (j-1, j), the kind (compare or swap) and a flag on the last event
// that the input caused. The first value of an array and any value arriving
// while the array is full cause no events.
// The stored values live in a row of cells, one per position. A cursor walks
// down the row, emitting a compare and then a swap, which moves the lower
// element up by one cell. An input that moves down k positions therefore
// emits 2*k+1 events (2*k when it lands at position 0), one per cycle after
// the accept cycle while the receiver does not stall; the next input is
// taken in the cycle after the last event is registered. A new input is
// accepted while that last event still waits in the output register.
// Reset empties the array and clears the output valid flag; cell contents
// are not cleared. A stalled receiver holds the current event and the walk
// pauses until it is taken.
module insertion_sort_event_trace_unit #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [isort_pkg::DATA_W-1:0] s_value,
    input  logic                                s_start_new,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [isort_pkg::POS_W-1:0]         m_pos_low,
    output logic [isort_pkg::POS_W-1:0]         m_pos_high,
    output logic                                m_event_kind,
    output logic                                m_last_event
);

    localparam int IW = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SWP  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [IW-1:0]                       j_reg, j_next;
    logic signed [isort_pkg::DATA_W-1:0] v_reg, v_next;
    logic                                m_valid_reg, m_valid_next;
    logic [isort_pkg::POS_W-1:0]         pos_low_reg, pos_low_next;
    logic [isort_pkg::POS_W-1:0]         pos_high_reg, pos_high_next;
    logic                                kind_reg, kind_next;
    logic                                last_reg, last_next;

    logic [IW-1:0]                       jm1;
    logic [CW-1:0]                       cnt0;
    logic                                out_free;
    logic                                take;
    logic                                placed;
    isort_pkg::cell_ctrl_t               ctrl;
    logic signed [isort_pkg::DATA_W-1:0] ins_d;

    logic signed [isort_pkg::DATA_W-1:0] cell_data [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]             cell_hit;
    logic                                hit;

    assign jm1      = j_reg - IW'(1);
    assign cnt0     = s_start_new ? '0 : count_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign take     = s_valid && s_ready;
    assign placed   = take && (cnt0 < CW'(MAX_ELEMENTS));
    assign hit      = |cell_hit;
    // a load writes the incoming request, the walk works on the held value
    assign ins_d    = (state_reg == ST_IDLE) ? s_value : v_reg;

    // cell control: depends only on registers, the input request and m_ready
    always_comb begin
        ctrl.op     = isort_pkg::OP_NONE;
        ctrl.hi_idx = isort_pkg::IDX_W'(j_reg);
        ctrl.lo_idx = isort_pkg::IDX_W'(jm1);
        if (state_reg == ST_IDLE) begin
            if (placed) begin
                ctrl.op     = isort_pkg::OP_LOAD;
                ctrl.hi_idx = isort_pkg::IDX_W'(cnt0);
            end
        end else if (state_reg == ST_SWP && out_free) begin
            ctrl.op = isort_pkg::OP_SWAP;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            logic signed [isort_pkg::DATA_W-1:0] prev_d;
            if (gi == 0) begin : g_first
                assign prev_d = v_reg;
            end else begin : g_rest
                assign prev_d = cell_data[gi-1];
            end
            isort_cell #(
                .IDX(gi)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .ins_value (ins_d),
                .prev_data (prev_d),
                .data      (cell_data[gi]),
                .hit       (cell_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        v_next        = v_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        pos_low_next  = pos_low_reg;
        pos_high_next = pos_high_reg;
        kind_next     = kind_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (placed) begin
                    count_next = cnt0 + CW'(1);
                    v_next     = s_value;
                    j_next     = cnt0[IW-1:0];
                    if (cnt0 != '0) begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    pos_low_next  = isort_pkg::POS_W'(jm1);
                    pos_high_next = isort_pkg::POS_W'(j_reg);
                    kind_next     = isort_pkg::EV_COMPARE;
                    last_next     = !hit;
                    state_next    = hit ? ST_SWP : ST_IDLE;
                end
            end
            ST_SWP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    pos_low_next  = isort_pkg::POS_W'(jm1);
                    pos_high_next = isort_pkg::POS_W'(j_reg);
                    kind_next     = isort_pkg::EV_SWAP;
                    last_next     = (jm1 == '0);
                    j_next        = jm1;
                    state_next    = (jm1 == '0) ? ST_IDLE : ST_CMP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        v_reg        <= v_next;
        pos_low_reg  <= pos_low_next;
        pos_high_reg <= pos_high_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_pos_low    = pos_low_reg;
    assign m_pos_high   = pos_high_reg;
    assign m_event_kind = kind_reg;
    assign m_last_event = last_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int  CAPACITY     = 16;
    localparam time CLK_PERIOD   = 10;
    localparam int  RANDOM_ITEMS = 190;
    localparam int  DRAIN_CYCLES = 4 * CAPACITY;
    localparam time WATCHDOG_NS  = 5_000_000;
    localparam int  N_DIRECTED   = 21;

    typedef struct packed {
        logic [isort_pkg::POS_W-1:0] lo;
        logic [isort_pkg::POS_W-1:0] hi;
        logic                        kind;
        logic                        last;
    } trace_ev_t;

    // typed rows carry their own expectation: nothing, or one closing compare (lo, hi)
    typedef struct packed {
        logic signed [isort_pkg::DATA_W-1:0] value;
        logic                                start_new;
        bit                                  typed;
        bit                                  one_cmp;
        logic [isort_pkg::POS_W-1:0]         lo;
        logic [isort_pkg::POS_W-1:0]         hi;
    } sort_row_t;

    localparam sort_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{32'sh0000_0000, 1'b1, 1'b1, 1'b0, 4'd0,  4'd0},   // first element: silent
        '{32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b1, 4'd0,  4'd1},
        '{32'sh8000_0000, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},   // falls to position 0
        '{32'sh0000_0000, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},   // equal value stops the walk
        '{32'shFFFF_FFFF, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b1, 4'd4,  4'd5},
        '{32'sh0000_0001, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'shFFFF_FFFE, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'sh0000_0064, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'shFFFF_FF9C, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'sh5555_5555, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'sh8000_0000, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'sh0000_0002, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'shFFFF_FFFD, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0},
        '{32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b1, 4'd14, 4'd15},  // fills the array
        '{32'sh1234_5678, 1'b0, 1'b1, 1'b0, 4'd0,  4'd0},   // full: dropped
        '{32'sh8000_0000, 1'b0, 1'b1, 1'b0, 4'd0,  4'd0},   // full: dropped
        '{32'shAAAA_AAAA, 1'b1, 1'b1, 1'b0, 4'd0,  4'd0},   // clear of a full array
        '{32'shFFFF_FFFF, 1'b0, 1'b1, 1'b1, 4'd0,  4'd1},
        '{32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0, 4'd0,  4'd0}
    };

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [isort_pkg::DATA_W-1:0] s_value = '0;
    logic                                s_start_new = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [isort_pkg::POS_W-1:0]         m_pos_low;
    logic [isort_pkg::POS_W-1:0]         m_pos_high;
    logic                                m_event_kind;
    logic                                m_last_event;

    // predictor state
    logic signed [isort_pkg::DATA_W-1:0] sorted_vals [CAPACITY];
    int                                  elem_count = 0;
    trace_ev_t                           expected_trace [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int events_checked = 0;
    int values_sent    = 0;
    int values_dropped = 0;
    int longest_trace  = 0;

    insertion_sort_event_trace_unit #(
        .MAX_ELEMENTS(CAPACITY)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .s_start_new(s_start_new),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pos_low(m_pos_low),
        .m_pos_high(m_pos_high),
        .m_event_kind(m_event_kind),
        .m_last_event(m_last_event)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Inserts one value into the predicted array; returns the trace length, -1 if dropped.
    function automatic int insert_and_trace(input logic signed [isort_pkg::DATA_W-1:0] v,
                                            input logic st, input bit keep);
        trace_ev_t                           evs [$];
        int                                  j;
        logic signed [isort_pkg::DATA_W-1:0] t;
        if (st)
            elem_count = 0;
        if (elem_count >= CAPACITY)
            return -1;
        j = elem_count;
        sorted_vals[j] = v;
        elem_count++;
        while (j > 0 && sorted_vals[j-1] > sorted_vals[j]) begin
            evs.push_back('{isort_pkg::POS_W'(j - 1), isort_pkg::POS_W'(j),
                            isort_pkg::EV_COMPARE, 1'b0});
            t = sorted_vals[j-1];
            sorted_vals[j-1] = sorted_vals[j];
            sorted_vals[j] = t;
            evs.push_back('{isort_pkg::POS_W'(j - 1), isort_pkg::POS_W'(j),
                            isort_pkg::EV_SWAP, 1'b0});
            j--;
        end
        if (j > 0)
            evs.push_back('{isort_pkg::POS_W'(j - 1), isort_pkg::POS_W'(j),
                            isort_pkg::EV_COMPARE, 1'b0});
        if (evs.size() > 0)
            evs[evs.size()-1].last = 1'b1;
        if (keep)
            foreach (evs[i])
                expected_trace.push_back(evs[i]);
        return evs.size();
    endfunction

    // Drives one request and returns at the edge that accepts it.
    task automatic send_value(input logic signed [isort_pkg::DATA_W-1:0] v, input logic st,
                              input bit keep, output int n_ev);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= v;
        s_start_new <= st;
        do @(posedge aclk); while (!s_ready);
        n_ev = insert_and_trace(v, st, keep);
        values_sent++;
        if (n_ev < 0)
            values_dropped++;
        if (n_ev > longest_trace)
            longest_trace = n_ev;
    endtask

    always @(posedge aclk) begin
        trace_ev_t got;
        trace_ev_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_pos_low, m_pos_high, m_event_kind, m_last_event};
                events_checked++;
                if (expected_trace.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected event: expected none, %s%0d hi=%0d kind=%0d last=%0d",
                             $time, "got lo=", got.lo, got.hi, got.kind, got.last);
                end else begin
                    want = expected_trace.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: event mismatch: expected lo=%0d hi=%0d kind=%0d last=%0d,",
                                 $time, want.lo, want.hi, want.kind, want.last);
                        $display("%0t:   got lo=%0d hi=%0d kind=%0d last=%0d",
                                 $time, got.lo, got.hi, got.kind, got.last);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    initial begin
        int                                  n_ev;
        int                                  random_items;
        int                                  seq_len;
        int                                  style;
        int                                  step;
        logic                                st;
        logic signed [isort_pkg::DATA_W-1:0] v;
        logic signed [isort_pkg::DATA_W-1:0] base;
        random_items = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct   = 12;
        sink_stall_pct = 74;
        foreach (DIRECTED_ROWS[r]) begin
            send_value(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].start_new,
                       !DIRECTED_ROWS[r].typed, n_ev);
            if (DIRECTED_ROWS[r].typed && DIRECTED_ROWS[r].one_cmp)
                expected_trace.push_back('{DIRECTED_ROWS[r].lo, DIRECTED_ROWS[r].hi,
                                           isort_pkg::EV_COMPARE, 1'b1});
        end

        // Mostly whole arrays opened by start_new, some overfilled; a few missing
        // or stray clears break the pattern.
        while (random_items < RANDOM_ITEMS) begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
                                                  : $urandom_range(1, CAPACITY);
            style = $urandom_range(0, 4);
            base  = $urandom;
            step  = $urandom_range(1, 1 << 20);
            for (int k = 0; k < seq_len; k++) begin
                case (random_items * 3 / RANDOM_ITEMS)
                    0: begin
                        src_idle_pct   = 12;
                        sink_stall_pct = 74;
                    end
                    1: begin
                        src_idle_pct   = 74;
                        sink_stall_pct = 12;
                    end
                    default: begin
                        src_idle_pct   = 0;
                        sink_stall_pct = 0;
                    end
                endcase
                st = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 24) == 0);
                case (style)
                    0: v = $urandom;
                    1: begin
                        v = $urandom_range(0, 7);
                        v = v - 4;
                    end
                    2: v = base - k * step;   // descending: long walks
                    3: v = base + k * step;   // ascending: single compares
                    default: begin
                        case ($urandom_range(0, 4))
                            0: v = 32'sh8000_0000;
                            1: v = 32'sh7FFF_FFFF;
                            2: v = '0;
                            3: v = '1;
                            default: v = $urandom;
                        endcase
                    end
                endcase
                send_value(v, st, 1'b1, n_ev);
                random_items++;
            end
        end
        s_valid <= 1'b0;

        while (expected_trace.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d values (%0d dropped on a full array), checked %0d trace events,",
                 values_sent, values_dropped, events_checked);
        $display("longest trace %0d events, %0d mismatches", longest_trace, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/insertion_sort_event_trace_unit.sv
tb/tb.sv
